// File: design/rrsi_pkg.sv
`timescale 1ns / 1ps
package rrsi_pkg;
	typedef enum logic [2:0] {
		CMD_APPEND  = 3'd0,
		CMD_RESTORE = 3'd1,
		CMD_FINISH  = 3'd2,
		CMD_FIND    = 3'd3,
		CMD_AT_POS  = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD_ARG   = 2'd2,
		ST_BAD_STATE = 2'd3
	} status_t;

	// number of record slots, bounded by the 6-bit slot fields
	localparam int CAPACITY = 64;
	localparam int IdW = 32;
	localparam int SlotW = 6;
	localparam int CntW = 7;
endpackage

// File: design/record_ring_slot_index_top.sv
`timescale 1ns / 1ps
// flow: every command first scans the slot row for the first empty slot, stopping once it
//   finds one or reaches the last slot, then executes and holds the result until it is taken
// throughput: one command at a time, next accepted the cycle after the result transfer
// reset: arst_n clears the index (count 0, next id 1, all slots empty) and max_payload to 255
// age order lives in a chain of cells, each holding slot and id, sorted by id, oldest at 0
module record_ring_slot_index_top
	import rrsi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[2:0] rec_id[34:3] slot_in[40:35] position[46:41] pay_len[54:47]
	// meta_valid[55] meta_next_id[87:56] meta_count[94:88] meta_next_slot[100:95]
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0] slot_out[7:2] assigned_id[39:8] replaced_id[71:40]
	// record_count[78:72] rewrite_needed[79]
	output logic [79:0]  m_tdata
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EXEC = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [7:0] max_payload_q;
	logic [103:0] cmd_q;
	// one bit per slot: slot holds a record
	logic [CAPACITY-1:0] occ_q;
	logic [CntW-1:0] count_q;
	logic [IdW-1:0] next_id_q;
	logic [SlotW-1:0] scan_q;
	logic [SlotW-1:0] free_q;
	logic free_found_q;
	logic [79:0] out_q;

	logic [2:0] c_cmd;
	logic [IdW-1:0] c_rid, c_mnext;
	logic [SlotW-1:0] c_sin, c_pos, c_mslot;
	logic [7:0] c_plen;
	logic c_mvalid;
	logic [CntW-1:0] c_mcount;
	assign c_cmd    = cmd_q[2:0];
	assign c_rid    = cmd_q[34:3];
	assign c_sin    = cmd_q[40:35];
	assign c_pos    = cmd_q[46:41];
	assign c_plen   = cmd_q[54:47];
	assign c_mvalid = cmd_q[55];
	assign c_mnext  = cmd_q[87:56];
	assign c_mcount = cmd_q[94:88];
	assign c_mslot  = cmd_q[100:95];

	// chain of cells
	logic [SlotW-1:0] cs [CAPACITY];
	logic [IdW-1:0] ci [CAPACITY];
	logic [CAPACITY-1:0] ld_left, ld_new, ld_right;
	logic [SlotW-1:0] new_slot;
	logic [IdW-1:0] new_id;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		rrsi_cell u_cell (
			.clk       (clk),
			.load_left (ld_left[g]),
			.load_new  (ld_new[g]),
			.load_right(ld_right[g]),
			.left_slot (cs[(g == 0) ? 0 : g - 1]),
			.left_id   (ci[(g == 0) ? 0 : g - 1]),
			.right_slot(cs[(g == CAPACITY - 1) ? g : g + 1]),
			.right_id  (ci[(g == CAPACITY - 1) ? g : g + 1]),
			.new_slot  (new_slot),
			.new_id    (new_id),
			.slot_q    (cs[g]),
			.id_q      (ci[g])
		);
	end

	// per-cell compare, independent per entry
	logic [CAPACITY-1:0] live, eq_hit, gt_hit;
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			live[k]   = CntW'(k) < count_q;
			eq_hit[k] = live[k] && ci[k] == c_rid;
			gt_hit[k] = live[k] && ci[k] > c_rid;
		end
	end

	// priority encode of first hit
	logic [SlotW-1:0] eq_idx, gt_idx;
	logic eq_any, gt_any;
	always_comb begin
		eq_idx = '0; gt_idx = SlotW'(count_q); eq_any = 1'b0; gt_any = 1'b0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (eq_hit[k]) begin eq_idx = SlotW'(k); eq_any = 1'b1; end
			if (gt_hit[k]) begin gt_idx = SlotW'(k); gt_any = 1'b1; end
		end
	end

	logic full;
	assign full = count_q >= CntW'(CAPACITY);
	logic [IdW-1:0] newest_id;
	assign newest_id = (count_q == '0) ? IdW'(1) :
		((ci[SlotW'(count_q - 1'b1)] == '1) ? '0 : ci[SlotW'(count_q - 1'b1)] + 1'b1);

	logic [SlotW-1:0] app_slot;
	assign app_slot = full ? cs[0] : free_q;

	logic do_append, do_insert, do_clear, cmd_fire;
	logic [1:0] st;
	logic [SlotW-1:0] so;
	logic [IdW-1:0] asg, ovr;
	logic rw;
	logic [IdW-1:0] fin_next;
	logic [SlotW-1:0] fin_slot;

	always_comb begin
		do_append = 1'b0; do_insert = 1'b0; do_clear = 1'b0;
		st = ST_OK; so = '0; asg = '0; ovr = '0; rw = 1'b0;
		fin_next = newest_id; fin_slot = full ? cs[0] : free_q;
		unique case (c_cmd)
			CMD_APPEND: begin
				if (c_plen == 8'd0 || c_plen > max_payload_q) st = ST_BAD_ARG;
				else if (next_id_q == '0) st = ST_BAD_STATE;
				else begin
					do_append = 1'b1;
					so = app_slot; asg = next_id_q;
					ovr = full ? ci[0] : '0;
				end
			end
			CMD_RESTORE: begin
				if (c_rid == '0 || {1'b0, c_sin} >= CntW'(CAPACITY)) st = ST_BAD_ARG;
				else if (full || occ_q[c_sin] || eq_any) st = ST_BAD_STATE;
				else begin do_insert = 1'b1; so = c_sin; end
			end
			CMD_FINISH: begin
				if (!c_mvalid || c_mcount > CntW'(CAPACITY) ||
						{1'b0, c_mslot} >= CntW'(CAPACITY))
					rw = 1'b1;
				else begin
					if (c_mnext == '0 || (newest_id != '0 && c_mnext > newest_id))
						fin_next = c_mnext;
					rw = c_mcount != count_q || c_mslot != fin_slot || c_mnext != fin_next;
				end
			end
			CMD_FIND: begin
				if (c_rid == '0) st = ST_BAD_ARG;
				else if (!eq_any) st = ST_NOT_FOUND;
				else so = cs[eq_idx];
			end
			CMD_AT_POS: begin
				if (CntW'(c_pos) >= count_q) st = ST_NOT_FOUND;
				else so = cs[c_pos];
			end
			CMD_CLEAR: do_clear = 1'b1;
			default: st = ST_BAD_ARG;
		endcase
	end

	assign cmd_fire = state_q == S_EXEC;

	// cell load controls
	always_comb begin
		ld_left = '0; ld_new = '0; ld_right = '0;
		new_slot = do_append ? app_slot : c_sin;
		new_id = do_append ? next_id_q : c_rid;
		if (cmd_fire && do_append) begin
			if (full) begin
				for (int k = 0; k < CAPACITY - 1; k++) ld_right[k] = 1'b1;
				ld_new[CAPACITY-1] = 1'b1;
			end else
				for (int k = 0; k < CAPACITY; k++) ld_new[k] = CntW'(k) == count_q;
		end else if (cmd_fire && do_insert) begin
			for (int k = 0; k < CAPACITY; k++) begin
				ld_new[k]  = k == int'(gt_idx);
				ld_left[k] = k > int'(gt_idx) && CntW'(k) <= count_q;
			end
		end
	end

	logic [IdW-1:0] ap_next;
	assign ap_next = (next_id_q == '1) ? '0 : next_id_q + 1'b1;
	logic [CntW-1:0] cnt_after;
	assign cnt_after = do_clear ? '0 :
		((do_insert || (do_append && !full)) ? count_q + 1'b1 : count_q);

	assign cfg_ready = 1'b1;
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_OUT;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_payload_q <= 8'd255;
			count_q <= '0;
			next_id_q <= IdW'(1);
			scan_q <= '0;
			free_q <= '0;
			free_found_q <= 1'b0;
			occ_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) max_payload_q <= cfg_data;
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					state_q <= S_SCAN; scan_q <= '0; free_q <= '0; free_found_q <= 1'b0;
				end
				// walk slots one a cycle for the first empty one
				S_SCAN: begin
					if (!free_found_q && !occ_q[scan_q]) begin
						free_q <= scan_q; free_found_q <= 1'b1;
					end
					if (int'(scan_q) == CAPACITY - 1 || free_found_q) state_q <= S_EXEC;
					else scan_q <= scan_q + 1'b1;
				end
				S_EXEC: begin
					state_q <= S_OUT;
					count_q <= cnt_after;
					if (do_clear) begin
						occ_q <= '0;
						next_id_q <= IdW'(1);
					end
					if (do_append) begin
						occ_q[app_slot] <= 1'b1;
						next_id_q <= ap_next;
					end
					if (do_insert) occ_q[c_sin] <= 1'b1;
					if (c_cmd == CMD_FINISH) next_id_q <= fin_next;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) cmd_q <= s_tdata;
		if (cmd_fire) out_q <= {rw, cnt_after, ovr, asg, so, st};
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not onehot");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(CAPACITY))
		else $error("count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && !m_tready |=> state_q == S_OUT)
		else $error("result dropped");
endmodule

// File: design/rrsi_cell.sv
`timescale 1ns / 1ps
// one age-order entry: holds a slot and its id, can load a new entry or from the left or right neighbor
module rrsi_cell
	import rrsi_pkg::*;
(
	input  logic             clk,
	input  logic             load_left,
	input  logic             load_new,
	input  logic             load_right,
	input  logic [SlotW-1:0] left_slot,
	input  logic [IdW-1:0]   left_id,
	input  logic [SlotW-1:0] right_slot,
	input  logic [IdW-1:0]   right_id,
	input  logic [SlotW-1:0] new_slot,
	input  logic [IdW-1:0]   new_id,
	output logic [SlotW-1:0] slot_q,
	output logic [IdW-1:0]   id_q
);
	always_ff @(posedge clk) begin
		if (load_new) begin
			slot_q <= new_slot;
			id_q   <= new_id;
		end else if (load_left) begin
			slot_q <= left_slot;
			id_q   <= left_id;
		end else if (load_right) begin
			slot_q <= right_slot;
			id_q   <= right_id;
		end
	end
endmodule
